// ===== src/ccr_pkg.sv =====
// Shared types and constants for the clock cache replacement block.
// Used by the interfaces, the controller, the datapath and the top level.
package ccr_pkg;

  localparam int SLOT_W = 10;
  localparam int FREE_W = 11;
  localparam int CFG_W  = 11;

  localparam int MAX_SLOTS_DEF   = 1024;
  localparam int COUNT_WIDTH_DEF = 8;

  localparam logic [CFG_W-1:0] BUFS_RESET = 11'd1024;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_HIT   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_HIT,
    ST_SCAN,
    ST_SUB,
    ST_SWEEP_RD,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // read address source for the count memory
  typedef enum logic [2:0] {
    RD_HIT,
    RD_ZERO,
    RD_NEXT,
    RD_HAND,
    RD_HAND_NEXT
  } rd_sel_t;

  // write source for the count memory
  typedef enum logic [2:0] {
    WR_NONE,
    WR_ZERO,
    WR_HIT,
    WR_SUB,
    WR_DEC
  } wr_sel_t;

  typedef struct packed {
    logic    take_item;
    logic    free_alloc;
    logic    hand_fix;
    logic    hand_adv;
    logic    min_init;
    logic    min_upd;
    logic    idx_clr;
    logic    idx_inc;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    res_hit;
    logic    res_victim;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic is_hit;
    logic free_avail;
    logic rd_zero;
    logic idx_last;
    logic clear_last;
  } status_t;

endpackage

// ===== src/ccr_if.sv =====
// Handshake channels of the clock cache replacement block: request,
// response and configuration write. Payload widths come from ccr_pkg.
interface ccr_req_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [ccr_pkg::SLOT_W-1:0] hit_slot;

  modport source (output valid, output mode, output hit_slot, input ready);
  modport sink (input valid, input mode, input hit_slot, output ready);
endinterface

interface ccr_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [ccr_pkg::SLOT_W-1:0] slot;
  logic                      from_free;
  logic [ccr_pkg::FREE_W-1:0] slots_handed_out;

  modport source (output valid, output slot, output from_free, output slots_handed_out,
                  input ready);
  modport sink (input valid, input slot, input from_free, input slots_handed_out,
                output ready);
endinterface

interface ccr_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [ccr_pkg::CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/clock_cache_replacement.sv =====
// CLOCK replacement with saturating usage counts over a pool of cache slots.
// After reset a clearing pass zeroes the count memory, during which no
// request is taken (configuration writes are). One request at a time runs
// through the sequencer: a free-pool allocation does not touch the count
// memory and a hit reads, then writes the count memory. An allocation that
// needs the clock sweep scans the slots for a zero count and then lets the
// hand pass slots, decrementing their counts, until it meets a zero count;
// when no zero count exists among the n managed slots, one pass subtracts
// the smallest count from all of them before the sweep. The count memory
// has a single read port. The next request is taken in the cycle a result
// enters the output register. Depends on ccr_pkg, ccr_if, ccr_ctrl,
// ccr_datapath and ccr_ram.
module clock_cache_replacement #(
  parameter int MAX_SLOTS   = ccr_pkg::MAX_SLOTS_DEF,
  parameter int COUNT_WIDTH = ccr_pkg::COUNT_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  ccr_req_if.sink    req,
  ccr_rsp_if.source  rsp,
  ccr_cfg_if.sink    cfg
);

  ccr_pkg::cmd_t    cmd;
  ccr_pkg::status_t status;

  assign cfg.ready = 1'b1;

  ccr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ccr_datapath #(
    .MAX_SLOTS   (MAX_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .item_mode      (req.mode),
    .item_hit_slot  (req.hit_slot),
    .cfg_valid      (cfg.valid),
    .cfg_data       (cfg.data),
    .out_slot       (rsp.slot),
    .out_from_free  (rsp.from_free),
    .out_handed_out (rsp.slots_handed_out)
  );

endmodule

// ===== src/ccr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ccr_ctrl.sv =====
// Sequencer for the clock cache replacement block.
// Depends on ccr_pkg for the state, command and status types.
module ccr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  input  ccr_pkg::status_t status,
  output ccr_pkg::cmd_t    cmd
);

  ccr_pkg::state_t state, state_next;
  logic            rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ccr_pkg::ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    req_ready      = 1'b0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    cmd            = '0;
    cmd.rd_sel     = ccr_pkg::RD_NEXT;
    cmd.wr_sel     = ccr_pkg::WR_NONE;
    case (state)
      ccr_pkg::ST_CLEAR: begin
        cmd.wr_sel  = ccr_pkg::WR_ZERO;
        cmd.idx_inc = 1'b1;
        if (status.clear_last) begin
          cmd.idx_inc = 1'b0;
          cmd.idx_clr = 1'b1;
          state_next  = ccr_pkg::ST_IDLE;
        end
      end
      ccr_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take_item = 1'b1;
          state_next    = ccr_pkg::ST_EXEC;
        end
      end
      ccr_pkg::ST_EXEC: begin
        if (status.is_hit) begin
          cmd.rd_sel = ccr_pkg::RD_HIT;
          state_next = ccr_pkg::ST_HIT;
        end else if (status.free_avail) begin
          cmd.free_alloc = 1'b1;
          state_next     = ccr_pkg::ST_DONE;
        end else begin
          cmd.hand_fix = 1'b1;
          cmd.min_init = 1'b1;
          cmd.idx_clr  = 1'b1;
          cmd.rd_sel   = ccr_pkg::RD_ZERO;
          state_next   = ccr_pkg::ST_SCAN;
        end
      end
      ccr_pkg::ST_HIT: begin
        cmd.wr_sel  = ccr_pkg::WR_HIT;
        cmd.res_hit = 1'b1;
        state_next  = ccr_pkg::ST_DONE;
      end
      ccr_pkg::ST_SCAN: begin
        // a zero count means the sweep will find a victim within one lap
        if (status.rd_zero) begin
          state_next = ccr_pkg::ST_SWEEP_RD;
        end else begin
          cmd.min_upd = 1'b1;
          if (status.idx_last) begin
            cmd.idx_clr = 1'b1;
            cmd.rd_sel  = ccr_pkg::RD_ZERO;
            state_next  = ccr_pkg::ST_SUB;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      ccr_pkg::ST_SUB: begin
        cmd.wr_sel = ccr_pkg::WR_SUB;
        if (status.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = ccr_pkg::ST_SWEEP_RD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ccr_pkg::ST_SWEEP_RD: begin
        cmd.rd_sel = ccr_pkg::RD_HAND;
        state_next = ccr_pkg::ST_SWEEP;
      end
      ccr_pkg::ST_SWEEP: begin
        cmd.hand_adv = 1'b1;
        if (status.rd_zero) begin
          cmd.res_victim = 1'b1;
          state_next     = ccr_pkg::ST_DONE;
        end else begin
          cmd.wr_sel = ccr_pkg::WR_DEC;
          cmd.rd_sel = ccr_pkg::RD_HAND_NEXT;
        end
      end
      ccr_pkg::ST_DONE: begin
        // hold the result until the output register frees up
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out   = 1'b1;
          rsp_valid_next = 1'b1;
          req_ready      = 1'b1;
          if (req_valid) begin
            cmd.take_item = 1'b1;
            state_next    = ccr_pkg::ST_EXEC;
          end else begin
            state_next = ccr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ccr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/ccr_datapath.sv =====
// Datapath of the clock cache replacement block: usage count memory, clock
// hand, free pool counter, scan registers and the output register.
// Depends on ccr_pkg and ccr_ram.
module ccr_datapath #(
  parameter int MAX_SLOTS   = ccr_pkg::MAX_SLOTS_DEF,
  parameter int COUNT_WIDTH = ccr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ccr_pkg::cmd_t              cmd,
  output ccr_pkg::status_t           status,
  input  logic                       item_mode,
  input  logic [ccr_pkg::SLOT_W-1:0] item_hit_slot,
  input  logic                       cfg_valid,
  input  logic [ccr_pkg::CFG_W-1:0]  cfg_data,
  output logic [ccr_pkg::SLOT_W-1:0] out_slot,
  output logic                       out_from_free,
  output logic [ccr_pkg::FREE_W-1:0] out_handed_out
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int NW = IW + 1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [IW-1:0] LAST_ENTRY = IW'(MAX_SLOTS - 1);

  logic [ccr_pkg::CFG_W-1:0]  buffers_in_use;
  logic [ccr_pkg::FREE_W-1:0] free_taken;
  logic [IW-1:0]              hand;
  logic [IW-1:0]              idx;
  logic [COUNT_WIDTH-1:0]     min_count;
  logic                       mode;
  logic [ccr_pkg::SLOT_W-1:0] hit_slot;
  logic [ccr_pkg::SLOT_W-1:0] res_slot;
  logic                       res_ff;

  logic [NW-1:0]          n_eff;
  logic [IW-1:0]          hand_next;
  logic [IW-1:0]          hit_addr;
  logic                   hit_in_range;
  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [IW-1:0]          ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  // clamp the slot count to 1..MAX_SLOTS
  always_comb begin
    if (buffers_in_use == '0) begin
      n_eff = NW'(1);
    end else if (32'(buffers_in_use) > MAX_SLOTS) begin
      n_eff = NW'(MAX_SLOTS);
    end else begin
      n_eff = NW'(buffers_in_use);
    end
  end

  assign hand_next    = (NW'(hand) + NW'(1) == n_eff) ? '0 : hand + IW'(1);
  assign hit_addr     = IW'(hit_slot);
  assign hit_in_range = 32'(hit_slot) < MAX_SLOTS;

  assign status.is_hit     = (mode == ccr_pkg::MODE_HIT);
  assign status.free_avail = 32'(free_taken) < 32'(n_eff);
  assign status.rd_zero    = (ram_rdata == '0);
  assign status.idx_last   = (NW'(idx) == n_eff - NW'(1));
  assign status.clear_last = (idx == LAST_ENTRY);

  always_comb begin
    case (cmd.rd_sel)
      ccr_pkg::RD_HIT:       ram_raddr = hit_addr;
      ccr_pkg::RD_ZERO:      ram_raddr = '0;
      ccr_pkg::RD_NEXT:      ram_raddr = idx + IW'(1);
      ccr_pkg::RD_HAND:      ram_raddr = hand;
      ccr_pkg::RD_HAND_NEXT: ram_raddr = hand_next;
      default:               ram_raddr = '0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    case (cmd.wr_sel)
      ccr_pkg::WR_NONE: begin
        ram_we = 1'b0;
      end
      ccr_pkg::WR_ZERO: begin
        ram_we = 1'b1;
      end
      ccr_pkg::WR_HIT: begin
        // saturate the count; drop hits to slots at or beyond MAX_SLOTS
        ram_we    = hit_in_range;
        ram_waddr = hit_addr;
        ram_wdata = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
      end
      ccr_pkg::WR_SUB: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata - min_count;
      end
      ccr_pkg::WR_DEC: begin
        ram_we    = 1'b1;
        ram_waddr = hand;
        ram_wdata = ram_rdata - COUNT_WIDTH'(1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ccr_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_SLOTS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      buffers_in_use <= ccr_pkg::BUFS_RESET;
      free_taken     <= '0;
      hand           <= '0;
      idx            <= '0;
    end else begin
      if (cfg_valid) begin
        buffers_in_use <= cfg_data;
      end
      if (cmd.free_alloc) begin
        free_taken <= free_taken + ccr_pkg::FREE_W'(1);
      end
      if (cmd.hand_fix && (NW'(hand) >= n_eff)) begin
        hand <= '0;
      end else if (cmd.hand_adv) begin
        hand <= hand_next;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      mode     <= item_mode;
      hit_slot <= item_hit_slot;
    end
    if (cmd.min_init) begin
      min_count <= COUNT_MAX;
    end else if (cmd.min_upd && (ram_rdata < min_count)) begin
      min_count <= ram_rdata;
    end
    if (cmd.free_alloc) begin
      res_slot <= ccr_pkg::SLOT_W'(free_taken);
      res_ff   <= 1'b1;
    end else if (cmd.res_hit) begin
      res_slot <= hit_slot;
      res_ff   <= 1'b0;
    end else if (cmd.res_victim) begin
      res_slot <= ccr_pkg::SLOT_W'(hand);
      res_ff   <= 1'b0;
    end
    if (cmd.load_out) begin
      out_slot       <= res_slot;
      out_from_free  <= res_ff;
      out_handed_out <= free_taken;
    end
  end

endmodule
